// File: hw/rtl/ptef_pkg.sv
// Shared types, constants and helper functions for the triangulation edge flip core.
package ptef_pkg;

	// Geometry of the adjacency store.
	localparam int MAX_VERTICES = 64;
	localparam int VTX_W        = 6;
	localparam int SIZE_W       = 7;
	localparam int CNT_W        = 11;
	localparam int ROW_W        = 64;
	localparam int FUNC_W       = 3;
	localparam int STAT_W       = 2;

	// Limits and reset value of the polygon size register.
	localparam logic [SIZE_W-1:0] SIZE_MIN   = 7'd3;
	localparam logic [SIZE_W-1:0] SIZE_MAX   = 7'd64;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	// Register index of the polygon size register.
	localparam logic REG_POLYGON_SIZE = 1'b0;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_FLIP  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_TEST  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd4;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

	typedef logic [ROW_W-1:0] row_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [VTX_W-1:0]  vertex_a;
		logic [VTX_W-1:0]  vertex_b;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VTX_W-1:0]  new_a;
		logic [VTX_W-1:0]  new_b;
		logic [CNT_W-1:0]  edge_count;
		logic              complete;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_B,
		S_CAP_B,
		S_DECIDE,
		S_ADD_B,
		S_FL_LO,
		S_FL_HI,
		S_FL_WHI,
		S_DONE
	} state_t;

	// Limit a written size to the supported vertex range.
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v < SIZE_MIN) r = SIZE_MIN;
		if (v > SIZE_MAX) r = SIZE_MAX;
		return r;
	endfunction

	// Row of the polygon ring for vertex i: its two ring neighbors, empty above n-1.
	function automatic row_t ring_row(input logic [VTX_W-1:0] i, input logic [SIZE_W-1:0] n);
		logic [SIZE_W-1:0] iw;
		logic [SIZE_W-1:0] nxt;
		logic [SIZE_W-1:0] prv;
		row_t              r;
		iw  = {1'b0, i};
		nxt = (iw + 7'd1 == n) ? 7'd0 : iw + 7'd1;
		prv = (iw == 7'd0) ? n - 7'd1 : iw - 7'd1;
		r   = '0;
		if (iw < n) begin
			r[nxt[VTX_W-1:0]] = 1'b1;
			r[prv[VTX_W-1:0]] = 1'b1;
		end
		return r;
	endfunction

	// Index of the lowest set bit, zero when the row is empty.
	function automatic logic [VTX_W-1:0] lowest_bit(input row_t x);
		logic [VTX_W-1:0] idx;
		idx = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (x[i]) idx = VTX_W'(i);
		end
		return idx;
	endfunction

endpackage

// File: hw/rtl/polygon_triangulation_edge_flip_core.sv
// Triangulation edge flip core: adjacency row memory, request sequencer and result register.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid / req_ready  ptef_pkg::req_t (func, vertex_a, vertex_b)
//   rsp       out        rsp_valid / rsp_ready  ptef_pkg::rsp_t (status, new_a, new_b, ...)
//   config    in         APB psel / penable     polygon_size at byte address 0
//
// A request that writes nothing passes S_RD_B, S_CAP_B, S_DECIDE and S_DONE; an add also
// passes S_ADD_B and a successful flip S_FL_LO, S_FL_HI and S_FL_WHI, and the next request is
// taken in S_IDLE after S_DONE. The single write port of the row memory sets this, as a flip
// rewrites four rows one per cycle and reads the two new rows during the first two writes.
// Reset or a size write returns the store to the ring at once through per-row valid bits.
// A new request is taken while the previous result still waits in the output register;
// a request only stalls in its last cycle when that register is still full.
module polygon_triangulation_edge_flip_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ptef_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ptef_pkg::rsp_t  rsp,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import ptef_pkg::*;

	// Control and configuration registers.
	state_t                  state_q, state_d;
	logic [SIZE_W-1:0]       size_q;
	logic [CNT_W-1:0]        edge_total_q;
	logic [MAX_VERTICES-1:0] row_vld_q;
	logic                    rd_vld_q;
	logic                    rsp_valid_q;

	// Payload registers.
	req_t                    req_q;
	logic [VTX_W-1:0]        rd_addr_q;
	row_t                    rd_data_q;
	row_t                    row_a_q;
	row_t                    row_b_q;
	logic [VTX_W-1:0]        lo_q;
	logic [VTX_W-1:0]        hi_q;
	logic [STAT_W-1:0]       stat_q;
	rsp_t                    rsp_q;

	// Adjacency row memory.
	row_t                    adj_mem [MAX_VERTICES];

	// Combinational signals.
	logic                    cfg_wr;
	logic                    clear_rows;
	logic [VTX_W-1:0]        rd_addr;
	logic                    mem_we;
	logic [VTX_W-1:0]        mem_waddr;
	row_t                    mem_wdata;
	row_t                    row_rd;
	row_t                    size_mask;
	row_t                    common;
	row_t                    common_rest;
	logic                    two_common;
	logic [VTX_W-1:0]        lo_c;
	logic [VTX_W-1:0]        hi_c;
	logic                    has_ab;
	logic                    distinct;
	logic                    pair_ok;
	logic [VTX_W-1:0]        diff;
	logic                    ring_edge;
	logic                    range_bad;
	logic                    do_add;
	logic                    do_flip;
	logic [STAT_W-1:0]       stat_c;
	logic [SIZE_W:0]         full_count;
	logic                    rsp_load;

	// Configuration port: one register, writes complete in the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POLYGON_SIZE);
	assign prdata = (paddr[2] == REG_POLYGON_SIZE) ? {25'd0, size_q} : 32'd0;

	// A row that has never been written since the last clear reads as its ring row.
	assign row_rd = rd_vld_q ? rd_data_q : ring_row(rd_addr_q, size_q);

	// Decision logic on the two captured rows.
	assign size_mask   = ~({ROW_W{1'b1}} << size_q);
	assign common      = row_a_q & row_b_q & size_mask;
	assign common_rest = common & (common - row_t'(1));
	assign two_common  = (|common) && (|common_rest) && !(|(common_rest & (common_rest - row_t'(1))));
	assign lo_c        = lowest_bit(common);
	assign hi_c        = lowest_bit(common_rest);
	assign has_ab      = row_a_q[req_q.vertex_b];
	assign distinct    = (req_q.vertex_a != req_q.vertex_b);
	assign pair_ok     = distinct && has_ab && two_common;
	assign diff        = (req_q.vertex_a > req_q.vertex_b) ? req_q.vertex_a - req_q.vertex_b
	                                                        : req_q.vertex_b - req_q.vertex_a;
	assign ring_edge   = (diff == 6'd1) || ({1'b0, diff} == size_q - 7'd1);
	assign range_bad   = (req_q.func inside {[FUNC_ADD:FUNC_QUERY]})
	                  && (({1'b0, req_q.vertex_a} >= size_q) || ({1'b0, req_q.vertex_b} >= size_q));
	assign do_add      = (req_q.func == FUNC_ADD) && !range_bad && distinct;
	assign do_flip     = (req_q.func == FUNC_FLIP) && !range_bad && pair_ok;
	assign clear_rows  = cfg_wr || ((state_q == S_DECIDE) && (req_q.func == FUNC_CLEAR));
	assign full_count  = {size_q, 1'b0} - 8'd3;
	assign rsp_load    = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	// Status of the request, settled in the decision cycle.
	always_comb begin
		stat_c = STAT_REFUSED;
		if (range_bad) begin
			stat_c = STAT_RANGE;
		end else begin
			case (req_q.func)
				FUNC_CLEAR: stat_c = STAT_OK;
				FUNC_ADD:   stat_c = distinct ? STAT_OK : STAT_REFUSED;
				FUNC_FLIP:  stat_c = pair_ok ? STAT_OK : STAT_REFUSED;
				FUNC_TEST:  stat_c = (pair_ok && !ring_edge) ? STAT_OK : STAT_REFUSED;
				FUNC_QUERY: stat_c = (distinct && has_ab) ? STAT_OK : STAT_REFUSED;
				default:    stat_c = STAT_REFUSED;
			endcase
		end
	end

	// Sequencer: next state, memory read address and row write-back.
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rd_addr   = req_q.vertex_b;
		mem_we    = 1'b0;
		mem_waddr = req_q.vertex_a;
		mem_wdata = row_a_q;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				rd_addr   = req.vertex_a;
				if (req_valid) state_d = S_RD_B;
			end
			S_RD_B: begin
				rd_addr = req_q.vertex_b;
				state_d = S_CAP_B;
			end
			S_CAP_B: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (do_add) begin
					mem_we    = 1'b1;
					mem_waddr = req_q.vertex_a;
					mem_wdata = row_a_q | (row_t'(1) << req_q.vertex_b);
					state_d   = S_ADD_B;
				end else if (do_flip) begin
					mem_we    = 1'b1;
					mem_waddr = req_q.vertex_a;
					mem_wdata = row_a_q & ~(row_t'(1) << req_q.vertex_b);
					rd_addr   = lo_c;
					state_d   = S_FL_LO;
				end else begin
					state_d = S_DONE;
				end
			end
			S_ADD_B: begin
				mem_we    = 1'b1;
				mem_waddr = req_q.vertex_b;
				mem_wdata = row_b_q | (row_t'(1) << req_q.vertex_a);
				state_d   = S_DONE;
			end
			S_FL_LO: begin
				mem_we    = 1'b1;
				mem_waddr = req_q.vertex_b;
				mem_wdata = row_b_q & ~(row_t'(1) << req_q.vertex_a);
				rd_addr   = hi_q;
				state_d   = S_FL_HI;
			end
			S_FL_HI: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q;
				mem_wdata = row_a_q | (row_t'(1) << hi_q);
				state_d   = S_FL_WHI;
			end
			S_FL_WHI: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = row_b_q | (row_t'(1) << lo_q);
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Row memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) adj_mem[mem_waddr] <= mem_wdata;
		rd_data_q <= adj_mem[rd_addr];
		rd_addr_q <= rd_addr;
	end

	// State, size, edge count, row valid bits and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			size_q       <= SIZE_RESET;
			edge_total_q <= CNT_W'(SIZE_RESET);
			row_vld_q    <= '0;
			rd_vld_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= clear_rows ? 1'b0 : row_vld_q[rd_addr];
			if (clear_rows) begin
				row_vld_q <= '0;
			end else if (mem_we) begin
				row_vld_q[mem_waddr] <= 1'b1;
			end
			if (cfg_wr) begin
				size_q       <= clamp_size(pwdata[SIZE_W-1:0]);
				edge_total_q <= CNT_W'(clamp_size(pwdata[SIZE_W-1:0]));
			end else if (state_q == S_DECIDE) begin
				if (req_q.func == FUNC_CLEAR && !range_bad) begin
					edge_total_q <= CNT_W'(size_q);
				end else if (do_add && !has_ab) begin
					edge_total_q <= edge_total_q + 11'd1;
				end else if (do_flip) begin
					edge_total_q <= edge_total_q - 11'd1;
				end
			end else if (state_q == S_FL_HI && !row_a_q[hi_q]) begin
				edge_total_q <= edge_total_q + 11'd1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, row capture and result assembly.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) req_q <= req;
		case (state_q)
			S_RD_B:  row_a_q <= row_rd;
			S_CAP_B: row_b_q <= row_rd;
			S_FL_LO: row_a_q <= row_rd;
			S_FL_HI: row_b_q <= row_rd;
			default: ;
		endcase
		if (state_q == S_DECIDE) begin
			stat_q <= stat_c;
			lo_q   <= do_flip ? lo_c : '0;
			hi_q   <= do_flip ? hi_c : '0;
		end
		if (rsp_load) begin
			rsp_q.status     <= stat_q;
			rsp_q.new_a      <= lo_q;
			rsp_q.new_b      <= hi_q;
			rsp_q.edge_count <= edge_total_q;
			rsp_q.complete   <= (edge_total_q == CNT_W'(full_count));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
